// ----- hdl/oshm_pkg.sv -----
// ----------------------------------------------------------------------------
// oshm_pkg
// types and codes shared by the one-shot modifier tracker modules
// ----------------------------------------------------------------------------
package oshm_pkg;

  // widths of the block's fields, fixed by the event format
  localparam int MaxMods  = 8;
  localparam int StW      = 3;
  localparam int KeyW     = 16;
  localparam int CountW   = 4;

  // per-modifier state codes
  localparam logic [StW-1:0] ST_OFF     = 3'd0;
  localparam logic [StW-1:0] ST_PRESSED = 3'd1;
  localparam logic [StW-1:0] ST_QUEUED  = 3'd2;
  localparam logic [StW-1:0] ST_LOCK    = 3'd3;
  localparam logic [StW-1:0] ST_END     = 3'd4;

  // event classes
  localparam logic [2:0] REQ_NORMAL  = 3'd0;
  localparam logic [2:0] REQ_TRIGGER = 3'd1;
  localparam logic [2:0] REQ_CANCEL  = 3'd2;
  localparam logic [2:0] REQ_IGNORED = 3'd3;
  localparam logic [2:0] REQ_ALL_OFF = 3'd4;

  typedef struct packed {
    logic [2:0]      req_type;
    logic            pressed;
    logic [2:0]      mod_index;
    logic [KeyW-1:0] keycode;
  } oshm_req_t;

  typedef struct packed {
    logic [MaxMods-1:0] mods_registered;
    logic [MaxMods-1:0] mods_unregistered;
    logic               key_release_valid;
    logic [KeyW-1:0]    key_release_code;
    logic [CountW-1:0]  changed_count;
    logic [MaxMods-1:0] mods_active;
  } oshm_result_t;

endpackage

// ----- hdl/oshm_step.sv -----
// ----------------------------------------------------------------------------
// oshm_step
// next-state and result logic for one key event, all modifiers in parallel
// ----------------------------------------------------------------------------
module oshm_step
  import oshm_pkg::*;
#(
  parameter int MOD_COUNT = 8
) (
  input  oshm_req_t       req,
  input  logic [StW-1:0]  st [MOD_COUNT],
  input  logic            unapplied,
  input  logic [KeyW-1:0] held_key,
  output logic [StW-1:0]  st_next [MOD_COUNT],
  output logic            unapplied_next,
  output logic [KeyW-1:0] held_key_next,
  output oshm_result_t    res
);

  logic [MOD_COUNT-1:0] act_now;
  logic                 any_active;
  logic                 clear_queued;
  logic                 sel;

  always_comb begin
    for (int i = 0; i < MOD_COUNT; i++) begin
      act_now[i] = (st[i] != ST_OFF);
    end
    any_active = |act_now;
    // a press that only consumes the pending one-shot keeps queued mods
    clear_queued = any_active && !(req.pressed && unapplied);
  end

  always_comb begin
    sel            = 1'b0;
    unapplied_next = unapplied;
    held_key_next  = held_key;
    res            = '0;

    case (req.req_type)
      REQ_NORMAL: begin
        if (req.pressed) begin
          if (any_active && unapplied) begin
            unapplied_next = 1'b0;
          end
          if (any_active && !unapplied && (held_key != '0)) begin
            res.key_release_valid = 1'b1;
            res.key_release_code  = held_key;
          end
          held_key_next = req.keycode;
        end else begin
          if (any_active && (req.keycode != '0)) begin
            res.key_release_valid = 1'b1;
            res.key_release_code  = req.keycode;
          end
          held_key_next = '0;
        end
      end
      REQ_CANCEL: begin
        unapplied_next = 1'b0;
      end
      REQ_ALL_OFF: begin
        for (int i = 0; i < MOD_COUNT; i++) begin
          res.changed_count = res.changed_count + CountW'(act_now[i]);
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < MOD_COUNT; i++) begin
      st_next[i] = st[i];
      sel = (req.mod_index == 3'(i));
      case (req.req_type)
        REQ_NORMAL: begin
          if (clear_queued && (st[i] == ST_QUEUED)) begin
            st_next[i] = ST_OFF;
          end
        end
        REQ_TRIGGER: begin
          if (sel && req.pressed) begin
            if (st[i] == ST_OFF) begin
              unapplied_next = (held_key == '0);
            end
            st_next[i] = (st[i] >= ST_END) ? ST_END : st[i] + StW'(1);
          end else if (sel) begin
            if (st[i] == ST_PRESSED) begin
              st_next[i] = unapplied ? ST_QUEUED : ST_OFF;
            end else if (st[i] >= ST_END) begin
              st_next[i] = ST_OFF;
            end
          end
        end
        REQ_CANCEL, REQ_ALL_OFF: begin
          st_next[i] = ST_OFF;
        end
        default: begin
        end
      endcase
      res.mods_registered[i]   = (st[i] == ST_OFF) && (st_next[i] != ST_OFF);
      res.mods_unregistered[i] = (st[i] != ST_OFF) && (st_next[i] == ST_OFF);
      res.mods_active[i]       = (st_next[i] != ST_OFF);
    end
  end

endmodule

// ----- hdl/one_shot_modifier_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// one_shot_modifier_tracker_unit
// one-shot modifier tracker: per-modifier state machines driven by
// pre-classified key events, one result beat per event beat
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------
//  input    in_valid / in_ready    req_type, pressed, mod_index, keycode
//  output   out_valid / out_ready  mods_registered, mods_unregistered,
//                                  key_release_valid, key_release_code,
//                                  changed_count, mods_active
//
//  an event beat is held in the input register, then the step logic
//  updates the modifier state and loads the result register at the same edge
//  one beat per cycle sustained while out_ready is high, set by the single
//  pass through the step logic
//  synchronous reset puts every modifier off, clears the flag and held key
//  a stalled output holds the input register; in_ready drops only when both
//  registers are full and out_ready is low
//
module one_shot_modifier_tracker_unit
  import oshm_pkg::*;
#(
  parameter int MOD_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst,
  // event channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic              pressed,
  input  logic [2:0]        mod_index,
  input  logic [KeyW-1:0]   keycode,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MaxMods-1:0] mods_registered,
  output logic [MaxMods-1:0] mods_unregistered,
  output logic              key_release_valid,
  output logic [KeyW-1:0]   key_release_code,
  output logic [CountW-1:0] changed_count,
  output logic [MaxMods-1:0] mods_active
);

  // input register
  logic         req_valid;
  oshm_req_t    req;

  // tracker state
  logic [StW-1:0]  mod_state [MOD_COUNT];
  logic            unapplied_flag;
  logic [KeyW-1:0] held_key;

  // step logic outputs
  logic [StW-1:0]  mod_state_next [MOD_COUNT];
  logic            unapplied_flag_next;
  logic [KeyW-1:0] held_key_next;
  oshm_result_t    res;

  // result register
  oshm_result_t    res_q;

  logic advance;

  // the queued event moves on when the result register is free or draining
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.req_type  <= req_type;
      req.pressed   <= pressed;
      req.mod_index <= mod_index;
      req.keycode   <= keycode;
    end
  end

  oshm_step #(
    .MOD_COUNT (MOD_COUNT)
  ) u_step (
    .req            (req),
    .st             (mod_state),
    .unapplied      (unapplied_flag),
    .held_key       (held_key),
    .st_next        (mod_state_next),
    .unapplied_next (unapplied_flag_next),
    .held_key_next  (held_key_next),
    .res            (res)
  );

  // state commits only when the event's result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOD_COUNT; i++) begin
        mod_state[i] <= ST_OFF;
      end
      unapplied_flag <= 1'b0;
      held_key       <= '0;
    end else if (advance) begin
      mod_state      <= mod_state_next;
      unapplied_flag <= unapplied_flag_next;
      held_key       <= held_key_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign mods_registered   = res_q.mods_registered;
  assign mods_unregistered = res_q.mods_unregistered;
  assign key_release_valid = res_q.key_release_valid;
  assign key_release_code  = res_q.key_release_code;
  assign changed_count     = res_q.changed_count;
  assign mods_active       = res_q.mods_active;

  // a modifier cannot both leave and return to off in one step
  a_reg_unreg_disjoint : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((mods_registered & mods_unregistered) == '0))
    else $error("modifier both registered and unregistered");

  // a newly registered modifier is active after the step
  a_reg_is_active : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((mods_registered & ~mods_active) == '0))
    else $error("registered modifier not active");

  // no release code without a release
  a_release_code_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_release_valid) |-> (key_release_code == '0))
    else $error("release code set without release");

  // a held event is not dropped while the result side stalls
  a_req_held : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !advance) |=> req_valid)
    else $error("pending event lost during stall");

endmodule
